>>> src/ugnq_pkg.sv
`timescale 1ns / 1ps
package ugnq_pkg;
    localparam int CMD_W  = 2;
    localparam int POS_W  = 20;
    localparam int CS_W   = 16;
    localparam int DIM_W  = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int STAT_W = 2;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_OFF  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS      = 2'd2;
endpackage

>>> src/ugnq_if.sv
`timescale 1ns / 1ps
interface ugnq_in_if;
    logic                        valid;
    logic                        ready;
    logic [ugnq_pkg::CMD_W-1:0]  cmd;
    logic [15:0]                 entity_id;
    logic signed [ugnq_pkg::POS_W-1:0] pos_x;
    logic signed [ugnq_pkg::POS_W-1:0] pos_y;
    modport source (output valid, cmd, entity_id, pos_x, pos_y, input ready);
    modport sink   (input valid, cmd, entity_id, pos_x, pos_y, output ready);
endinterface

interface ugnq_out_if;
    logic                         valid;
    logic                         ready;
    logic [15:0]                  found_id;
    logic                         found_valid;
    logic                         last;
    logic [ugnq_pkg::STAT_W-1:0]  status;
    modport source (output valid, found_id, found_valid, last, status, input ready);
    modport sink   (input valid, found_id, found_valid, last, status, output ready);
endinterface

interface ugnq_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ugnq_pkg::CFG_IDX_W-1:0]  index;
    logic [ugnq_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> src/ugnq_ram.sv
`timescale 1ns / 1ps
module ugnq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> src/uniform_grid_neighbour_query_top.sv
`timescale 1ns / 1ps
// Uniform-grid spatial hash for a collision broad phase. One transaction is
// taken at a time; in_ch.ready stays low until its last result has been
// loaded into the output register. Insert and query first floor-divide both
// coordinates by cell_size with one shared restoring divider, one quotient
// bit per cycle, x first and then y, then check the home cell against the grid.
// Insert then writes its count and entry if the bucket has room and loads
// its result; an off-grid command loads an off-grid status instead. A query
// walks the nine cells around its home cell: an on-grid cell passes S_CELL,
// S_CNT, S_ENT and S_EMIT, with one more S_ENT and S_EMIT per stored id; a
// cell off the grid passes S_CELL and S_EMIT. Any result can wait on
// out_ch.ready. Clear sweeps the count memory one cell per cycle; after
// reset the same sweep runs once before the first transaction is taken.
// Config writes are accepted at any time but belong only to idle periods.
module uniform_grid_neighbour_query_top #(
    parameter int MAX_COLUMNS  = 32,
    parameter int MAX_ROWS     = 32,
    parameter int BUCKET_DEPTH = 4,
    parameter int ID_BITS      = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    ugnq_in_if.sink    in_ch,
    ugnq_out_if.source out_ch,
    ugnq_cfg_if.sink   cfg_ch
);
    import ugnq_pkg::*;

    localparam int COL_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CELLS   = MAX_COLUMNS * MAX_ROWS;
    localparam int CELL_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int SLOT_W  = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int ENT_N   = CELLS * BUCKET_DEPTH;
    localparam int ENT_W   = (ENT_N > 1) ? $clog2(ENT_N) : 1;
    localparam int CNT_W   = 3;
    localparam int MAG_W   = POS_W;          // magnitude of a 20-bit value
    localparam int REM_W   = CS_W + 1;
    localparam int QI_W    = $clog2(MAG_W + 1);
    localparam int ID_OUT  = 16;

    typedef enum logic [10:0] {
        S_INIT  = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_DIV   = 11'b00000000100,
        S_CHECK = 11'b00000001000,
        S_INS   = 11'b00000010000,
        S_CELL  = 11'b00000100000,
        S_CNT   = 11'b00001000000,
        S_ENT   = 11'b00010000000,
        S_EMIT  = 11'b00100000000,
        S_RESP  = 11'b01000000000,
        S_CLR   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [CS_W-1:0]  cell_size_reg;
    logic [DIM_W-1:0] columns_reg, rows_reg;
    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg <= CS_W'(512);
            columns_reg   <= DIM_W'(32);
            rows_reg      <= DIM_W'(32);
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                REG_CELL_SIZE: cell_size_reg <= cfg_ch.data;
                REG_COLUMNS:   columns_reg   <= cfg_ch.data[DIM_W-1:0];
                REG_ROWS:      rows_reg      <= cfg_ch.data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped divisor and grid size (9-bit covers 1..256)
    logic [CS_W-1:0] divisor;
    logic [8:0]      cols_eff, rows_eff;
    assign divisor = (cell_size_reg == '0) ? CS_W'(1) : cell_size_reg;
    always_comb
    begin
        cols_eff = (columns_reg == '0) ? 9'd1 : 9'(columns_reg);
        if (cols_eff > 9'(MAX_COLUMNS)) cols_eff = 9'(MAX_COLUMNS);
        rows_eff = (rows_reg == '0) ? 9'd1 : 9'(rows_reg);
        if (rows_eff > 9'(MAX_ROWS)) rows_eff = 9'(MAX_ROWS);
    end

    // captured transaction
    logic [CMD_W-1:0]          cmd_reg;
    logic [ID_BITS-1:0]        id_reg;
    logic signed [POS_W-1:0]   py_reg;

    // shared divider: divides |p| then corrects for floor on negatives
    logic              axis_reg;          // 0: x, 1: y
    logic [MAG_W-1:0]  num_reg;           // shifts out dividend, in quotient
    logic [REM_W-1:0]  rem_reg;
    logic [QI_W-1:0]   bit_cnt_reg;
    logic              neg_reg;
    logic signed [POS_W:0] qx_reg, qy_reg;

    logic [REM_W-1:0] rem_shift, rem_sub;
    logic             take;
    assign rem_shift = {rem_reg[REM_W-2:0], num_reg[MAG_W-1]};
    assign take      = rem_shift >= REM_W'(divisor);
    assign rem_sub   = take ? rem_shift - REM_W'(divisor) : rem_shift;

    // final floor quotient: q = -(mag/d) - (rem != 0) for negatives
    logic [MAG_W-1:0]     q_mag;
    logic                 rem_nz;
    logic signed [POS_W:0] q_final;
    assign q_mag  = {num_reg[MAG_W-2:0], take};
    assign rem_nz = rem_sub != '0;
    assign q_final = neg_reg
        ? -$signed({1'b0, q_mag}) - $signed((POS_W+1)'(rem_nz))
        : $signed({1'b0, q_mag});

    // query walk
    logic [1:0]        dr_reg, dc_reg;     // 0..2 standing for -1..+1
    logic signed [POS_W+1:0] r_cur, c_cur;
    logic              cell_ok;
    logic [CELL_W-1:0] cell_addr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  slot_reg;
    logic              found_any_reg;     // hold_id_reg carries an id
    logic [ID_BITS-1:0] hold_id_reg;
    assign r_cur = $signed({qy_reg[POS_W], qy_reg}) + $signed({{POS_W{1'b0}}, dr_reg})
                 - $signed((POS_W+2)'(1));
    assign c_cur = $signed({qx_reg[POS_W], qx_reg}) + $signed({{POS_W{1'b0}}, dc_reg})
                 - $signed((POS_W+2)'(1));
    assign cell_ok = (r_cur >= 0) && (c_cur >= 0)
                  && (r_cur < $signed((POS_W+2)'(rows_eff)))
                  && (c_cur < $signed((POS_W+2)'(cols_eff)));

    // EMIT decides among: emit entry, advance to next cell, or finish
    logic [CNT_W-1:0] cnt_clamped;
    assign cnt_clamped = (cnt_reg > CNT_W'(BUCKET_DEPTH)) ? CNT_W'(BUCKET_DEPTH) : cnt_reg;
    logic walk_done;
    assign walk_done = (dr_reg == 2'd2) && (dc_reg == 2'd2);

    logic off_grid;
    assign off_grid = (qx_reg < 0) || (qy_reg < 0)
                   || (qx_reg >= $signed((POS_W+1)'(cols_eff)))
                   || (qy_reg >= $signed((POS_W+1)'(rows_eff)));

    // memories
    logic              cnt_we;
    logic [CELL_W-1:0] cnt_waddr, cnt_raddr;
    logic [CNT_W-1:0]  cnt_wdata, cnt_rdata;
    logic              ent_we;
    logic [ENT_W-1:0]  ent_waddr, ent_raddr;
    logic [ID_BITS-1:0] ent_rdata;

    ugnq_ram #(.WIDTH(CNT_W), .DEPTH(CELLS)) u_cnt_ram (
        .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .raddr(cnt_raddr), .rdata(cnt_rdata)
    );
    ugnq_ram #(.WIDTH(ID_BITS), .DEPTH(ENT_N)) u_ent_ram (
        .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(id_reg),
        .raddr(ent_raddr), .rdata(ent_rdata)
    );

    logic [CELL_W-1:0] home_cell, walk_cell;
    assign home_cell = CELL_W'(qy_reg[ROW_W-1:0]) * CELL_W'(MAX_COLUMNS)
                     + CELL_W'(qx_reg[COL_W-1:0]);
    assign walk_cell = CELL_W'(r_cur[ROW_W-1:0]) * CELL_W'(MAX_COLUMNS)
                     + CELL_W'(c_cur[COL_W-1:0]);

    // output register
    logic              ovalid_reg;
    logic [ID_OUT-1:0] oid_reg;
    logic              ofv_reg, olast_reg;
    logic [STAT_W-1:0] ostat_reg;
    assign out_ch.valid       = ovalid_reg;
    assign out_ch.found_id    = oid_reg;
    assign out_ch.found_valid = ofv_reg;
    assign out_ch.last        = olast_reg;
    assign out_ch.status      = ostat_reg;

    logic [CELL_W-1:0] sweep_reg;
    assign in_ch.ready = (state_reg == S_IDLE);

    logic in_fire, out_free;
    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_free = !ovalid_reg || out_ch.ready;

    // a result transaction is loaded into the output register this cycle
    logic out_load;
    always_comb
    begin
        out_load = 1'b0;
        if (out_free)
        begin
            case (state_reg)
                S_INS, S_RESP: out_load = 1'b1;
                S_EMIT:        out_load = (slot_reg < cnt_clamped) ? found_any_reg : walk_done;
                default:       out_load = 1'b0;
            endcase
        end
    end

    // memory port drive
    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_waddr = home_cell;
        cnt_wdata = cnt_rdata + CNT_W'(1);
        cnt_raddr = (state_reg == S_CELL) ? walk_cell : home_cell;
        ent_we    = 1'b0;
        ent_waddr = ENT_W'(home_cell) * ENT_W'(BUCKET_DEPTH) + ENT_W'(cnt_rdata[SLOT_W-1:0]);
        ent_raddr = ENT_W'(cell_addr_reg) * ENT_W'(BUCKET_DEPTH)
                  + ENT_W'(slot_reg[SLOT_W-1:0]);
        if (state_reg == S_INIT || state_reg == S_CLR)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = sweep_reg;
            cnt_wdata = '0;
        end
        else if (state_reg == S_INS && out_free && !off_grid
                 && cnt_rdata < CNT_W'(BUCKET_DEPTH))
        begin
            cnt_we = 1'b1;
            ent_we = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:  if (sweep_reg == CELL_W'(CELLS - 1)) state_next = S_IDLE;
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_ch.cmd == CMD_CLEAR) state_next = S_CLR;
                    else if (in_ch.cmd == CMD_INSERT || in_ch.cmd == CMD_QUERY)
                        state_next = S_DIV;
                end
            end
            S_DIV:   if (bit_cnt_reg == QI_W'(MAG_W - 1) && axis_reg) state_next = S_CHECK;
            S_CHECK:
            begin
                if (off_grid) state_next = S_RESP;
                else if (cmd_reg == CMD_INSERT) state_next = S_INS;
                else state_next = S_CELL;
            end
            S_INS:   if (out_free) state_next = S_IDLE;
            S_CELL:  state_next = cell_ok ? S_CNT : S_EMIT;
            S_CNT:   state_next = S_ENT;
            S_ENT:   state_next = S_EMIT;
            S_EMIT:
            begin
                if (out_free)
                begin
                    if (slot_reg < cnt_clamped) state_next = S_ENT;
                    else if (!walk_done) state_next = S_CELL;
                    else state_next = S_IDLE;
                end
            end
            S_RESP:  if (out_free) state_next = S_IDLE;
            S_CLR:   if (sweep_reg == CELL_W'(CELLS - 1)) state_next = S_RESP;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            sweep_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load) ovalid_reg <= 1'b1;
            else if (out_ch.ready) ovalid_reg <= 1'b0;
            case (state_reg)
                S_INIT, S_CLR: sweep_reg <= sweep_reg + CELL_W'(1);
                S_IDLE:
                begin
                    sweep_reg <= '0;
                    if (in_fire)
                    begin
                        cmd_reg       <= in_ch.cmd;
                        id_reg        <= ID_BITS'(in_ch.entity_id);
                        py_reg        <= in_ch.pos_y;
                        axis_reg      <= 1'b0;
                        bit_cnt_reg   <= '0;
                        rem_reg       <= '0;
                        neg_reg       <= in_ch.pos_x[POS_W-1];
                        num_reg       <= in_ch.pos_x[POS_W-1]
                                         ? MAG_W'(-in_ch.pos_x) : MAG_W'(in_ch.pos_x);
                        dr_reg        <= '0;
                        dc_reg        <= '0;
                        found_any_reg <= 1'b0;
                    end
                end
                S_DIV:
                begin
                    num_reg     <= q_mag;
                    rem_reg     <= rem_sub;
                    bit_cnt_reg <= bit_cnt_reg + QI_W'(1);
                    if (bit_cnt_reg == QI_W'(MAG_W - 1))
                    begin
                        bit_cnt_reg <= '0;
                        rem_reg     <= '0;
                        if (!axis_reg)
                        begin
                            qx_reg   <= q_final;
                            axis_reg <= 1'b1;
                            neg_reg  <= py_reg[POS_W-1];
                            num_reg  <= py_reg[POS_W-1] ? MAG_W'(-py_reg) : MAG_W'(py_reg);
                        end
                        else
                        begin
                            qy_reg <= q_final;
                        end
                    end
                end
                S_INS:
                begin
                    if (out_free)
                    begin
                        oid_reg    <= '0;
                        ofv_reg    <= 1'b0;
                        olast_reg  <= 1'b1;
                        ostat_reg  <= (cnt_rdata < CNT_W'(BUCKET_DEPTH)) ? ST_OK : ST_FULL;
                    end
                end
                S_CELL:
                begin
                    cell_addr_reg <= walk_cell;
                    slot_reg      <= '0;
                    cnt_reg       <= '0;
                end
                S_CNT:  cnt_reg <= cnt_rdata;
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        if (slot_reg < cnt_clamped)
                        begin
                            // hold one id back so the final one can carry last
                            if (found_any_reg)
                            begin
                                oid_reg   <= ID_OUT'(hold_id_reg);
                                ofv_reg   <= 1'b1;
                                olast_reg <= 1'b0;
                                ostat_reg <= ST_OK;
                            end
                            hold_id_reg   <= ent_rdata;
                            found_any_reg <= 1'b1;
                            slot_reg      <= slot_reg + CNT_W'(1);
                        end
                        else if (!walk_done)
                        begin
                            if (dc_reg == 2'd2)
                            begin
                                dc_reg <= '0;
                                dr_reg <= dr_reg + 2'd1;
                            end
                            else
                            begin
                                dc_reg <= dc_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            // held id goes out as the final result, or an empty one
                            oid_reg   <= found_any_reg ? ID_OUT'(hold_id_reg) : '0;
                            ofv_reg   <= found_any_reg;
                            olast_reg <= 1'b1;
                            ostat_reg <= ST_OK;
                        end
                    end
                end
                S_RESP:
                begin
                    // reached from clear, or from an off-grid insert or query
                    if (out_free)
                    begin
                        oid_reg   <= '0;
                        ofv_reg   <= 1'b0;
                        olast_reg <= 1'b1;
                        ostat_reg <= (cmd_reg == CMD_CLEAR) ? ST_OK : ST_OFF;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

>>> tb/uniform_grid_neighbour_query_top_tb.sv
`timescale 1ns / 1ps
module uniform_grid_neighbour_query_top_tb;
    import ugnq_pkg::*;

    localparam int NCOLS = 32;
    localparam int NROWS = 32;
    localparam int DEPTH = 4;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [15:0]       id;
        logic              fvalid;
        logic              last;
        logic [STAT_W-1:0] status;
    } hit_t;

    logic clk;
    logic rst_n;
    ugnq_in_if  in_ch ();
    ugnq_out_if out_ch ();
    ugnq_cfg_if cfg_ch ();

    uniform_grid_neighbour_query_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg_ch (cfg_ch.sink)
    );

    // Shadow grid state and register copies
    logic [15:0] grid_ids [NCOLS*NROWS*DEPTH];
    int          grid_cnt [NCOLS*NROWS];
    int          cell_size_q;
    int          cols_q;
    int          rows_q;

    hit_t expected_hits[$];
    int   errors;
    int   idle_cycles;
    bit   quiet;       // last phase: no random gaps on either side

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Floor division for positive divisor
    function automatic int floor_div(int p, int d);
        int q;
        q = p / d;
        if ((p % d) != 0 && p < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic hit_t mk_hit(logic [15:0] id, logic v, logic l, logic [STAT_W-1:0] s);
        hit_t h;
        h.id = id;
        h.fvalid = v;
        h.last = l;
        h.status = s;
        return h;
    endfunction

    // Append one expected result to the end of the queue
    function automatic void add_hit(hit_t h);
        expected_hits.insert(expected_hits.size(), h);
    endfunction

    // Compute the results that one command produces, updating the shadow grid
    task automatic predict_grid(logic [CMD_W-1:0] cmd, logic [15:0] eid,
                                logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py);
        int d, nc, nr, col, row, cell_idx, n, r, c;
        bit off;
        d  = (cell_size_q == 0) ? 1 : cell_size_q;
        nc = (cols_q < 1) ? 1 : ((cols_q > NCOLS) ? NCOLS : cols_q);
        nr = (rows_q < 1) ? 1 : ((rows_q > NROWS) ? NROWS : rows_q);
        if (cmd == CMD_CLEAR)
        begin
            foreach (grid_cnt[i])
                grid_cnt[i] = 0;
            add_hit(mk_hit(16'd0, 1'b0, 1'b1, ST_OK));
            return;
        end
        if (cmd != CMD_INSERT && cmd != CMD_QUERY)
            return;
        col = floor_div(int'(px), d);
        row = floor_div(int'(py), d);
        off = (col < 0 || row < 0 || col >= nc || row >= nr);
        if (off)
        begin
            add_hit(mk_hit(16'd0, 1'b0, 1'b1, ST_OFF));
            return;
        end
        if (cmd == CMD_INSERT)
        begin
            cell_idx = row * NCOLS + col;
            if (grid_cnt[cell_idx] >= DEPTH)
                add_hit(mk_hit(16'd0, 1'b0, 1'b1, ST_FULL));
            else
            begin
                grid_ids[cell_idx*DEPTH + grid_cnt[cell_idx]] = eid;
                grid_cnt[cell_idx]++;
                add_hit(mk_hit(16'd0, 1'b0, 1'b1, ST_OK));
            end
            return;
        end
        n = 0;
        for (r = row - 1; r <= row + 1; r++)
        begin
            if (r < 0 || r >= nr)
                continue;
            for (c = col - 1; c <= col + 1; c++)
            begin
                if (c < 0 || c >= nc)
                    continue;
                cell_idx = r * NCOLS + c;
                for (int k = 0; k < grid_cnt[cell_idx]; k++)
                begin
                    add_hit(mk_hit(grid_ids[cell_idx*DEPTH + k], 1'b1, 1'b0, ST_OK));
                    n++;
                end
            end
        end
        if (n == 0)
            add_hit(mk_hit(16'd0, 1'b0, 1'b1, ST_OK));
        else
            expected_hits[$].last = 1'b1;
    endtask

    // Random gap on the sending side; valid drops for the gap
    task automatic maybe_gap();
        if (!quiet && $urandom_range(3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(9, 1)) @(negedge clk);
        end
    endtask

    // Send one command transaction; valid stays up until the next send or drain
    task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [15:0] eid,
                            logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py);
        maybe_gap();
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= cmd;
        in_ch.entity_id <= eid;
        in_ch.pos_x     <= px;
        in_ch.pos_y     <= py;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_grid(cmd, eid, px, py);
        @(negedge clk);
    endtask

    // Wait for all expected transactions, then let any in-flight work finish
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_hits.size() != 0)
            @(negedge clk);
        repeat (1200) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            REG_CELL_SIZE: cell_size_q = val;
            REG_COLUMNS:   cols_q = val[DIM_W-1:0];
            REG_ROWS:      rows_q = val[DIM_W-1:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_grid(logic [15:0] cs, logic [15:0] nc, logic [15:0] nr);
        drain();
        write_reg(REG_CELL_SIZE, cs);
        write_reg(REG_COLUMNS, nc);
        write_reg(REG_ROWS, nr);
        cfg_ch.valid <= 1'b0;
    endtask

    // Position inside cell idx on one axis, with random fractional offset
    function automatic logic signed [POS_W-1:0] cell_pos(int idx);
        int d;
        d = (cell_size_q == 0) ? 1 : cell_size_q;
        return POS_W'(idx * d + int'($urandom_range(d - 1)));
    endfunction

    // Directed: extremes, each command, off-grid, full bucket, unused command
    task automatic test_directed();
        send_cmd(CMD_CLEAR, 16'hFFFF, 20'sh7FFFF, 20'sh80000);
        send_cmd(CMD_QUERY, 16'd0, 20'sd0, 20'sd0);            // empty query
        for (int i = 0; i < 5; i++)                            // fifth overflows
            send_cmd(CMD_INSERT, (i == 0) ? 16'hFFFF : 16'(i), 20'sd5, 20'sd7);
        send_cmd(CMD_INSERT, 16'h00AA, 20'sd512, 20'sd0);
        send_cmd(CMD_INSERT, 16'h5555, 20'sh80000, 20'sd0);    // off grid, negative
        send_cmd(CMD_INSERT, 16'h5555, 20'sh7FFFF, 20'sh7FFFF);// off grid, far
        send_cmd(CMD_INSERT, 16'h1234, 20'sd16383, 20'sd16383);// last cell corner
        send_cmd(CMD_QUERY, 16'd0, 20'sd0, 20'sd0);            // corner query
        send_cmd(CMD_QUERY, 16'd0, 20'sd600, 20'sd600);
        send_cmd(CMD_QUERY, 16'd0, 20'sd16383, 20'sd16383);
        send_cmd(CMD_QUERY, 16'd0, -20'sd1, 20'sd0);           // off-grid query
        send_cmd(CMD_UNUSED, 16'hBEEF, 20'sd0, 20'sd0);        // unused command
        send_cmd(CMD_CLEAR, 16'd0, 20'sd0, 20'sd0);
        send_cmd(CMD_QUERY, 16'd0, 20'sd5, 20'sd7);
    endtask

    // Register extremes: zero and oversize values
    task automatic test_reg_extremes();
        set_grid(16'd0, 16'd0, 16'd0);          // acts as 1x1, cell size 1
        send_cmd(CMD_INSERT, 16'h0101, 20'sd0, 20'sd0);
        send_cmd(CMD_INSERT, 16'h0102, 20'sd1, 20'sd0);
        send_cmd(CMD_QUERY, 16'd0, 20'sd0, 20'sd0);
        set_grid(16'hFFFF, 16'h003F, 16'h0021); // oversize counts clamp
        send_cmd(CMD_INSERT, 16'h0201, 20'sh7FFFF, 20'sd0);
        send_cmd(CMD_QUERY, 16'd0, 20'sd70000, 20'sd100);
        send_cmd(CMD_CLEAR, 16'd0, 20'sd0, 20'sd0);
    endtask

    // Random commands over the current grid; on a small grid buckets get full
    task automatic test_random(int items);
        logic [CMD_W-1:0] cmd;
        int sel;
        for (int i = 0; i < items; i++)
        begin
            sel = $urandom_range(99);
            if (sel < 2)
                cmd = CMD_CLEAR;
            else if (sel < 5)
                cmd = CMD_UNUSED;
            else if (sel < 55)
                cmd = CMD_INSERT;
            else
                cmd = CMD_QUERY;
            if ($urandom_range(9) == 0)
                send_cmd(cmd, 16'($urandom), 20'($urandom), 20'($urandom));
            else
                send_cmd(cmd, 16'($urandom),
                         cell_pos(int'($urandom_range(cols_q)) - (($urandom_range(7) == 0) ? 1 : 0)),
                         cell_pos(int'($urandom_range(rows_q)) - (($urandom_range(7) == 0) ? 1 : 0)));
        end
    endtask

    // Result checker: compares each result with the expected queue
    always @(posedge clk)
    begin
        hit_t got, want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = mk_hit(out_ch.found_id, out_ch.found_valid, out_ch.last, out_ch.status);
            if (expected_hits.size() == 0)
            begin
                $display("%0t: unexpected result transaction %h", $time, got);
                errors++;
            end
            else
            begin
                want = expected_hits.pop_front();
                if (got.id !== want.id)
                begin
                    $display("%0t: found_id expected %h actual %h", $time, want.id, got.id);
                    errors++;
                end
                if (got.fvalid !== want.fvalid)
                begin
                    $display("%0t: found_valid expected %b actual %b", $time, want.fvalid, got.fvalid);
                    errors++;
                end
                if (got.last !== want.last)
                begin
                    $display("%0t: last expected %b actual %b", $time, want.last, got.last);
                    errors++;
                end
                if (got.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                    errors++;
                end
            end
        end
    end

    // Receiver stalls come in random bursts, none in the quiet phase
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(4) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(9, 1)) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        idle_cycles = 0;
        quiet = 1'b0;
        cell_size_q = 512;
        cols_q = 32;
        rows_q = 32;
        foreach (grid_cnt[i])
            grid_cnt[i] = 0;
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_CLEAR;
        in_ch.entity_id = '0;
        in_ch.pos_x = '0;
        in_ch.pos_y = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_CELL_SIZE;
        cfg_ch.data = '0;
        rst_n = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_reg_extremes();
        set_grid(16'd48, 16'd3, 16'd3);   // tiny grid: frequent full buckets
        test_random(60);
        set_grid(16'd1000, 16'd7, 16'd5);
        test_random(70);
        quiet = 1'b1;                     // no random gaps or stalls from here on
        set_grid(16'd512, 16'd32, 16'd32);
        test_random(70);
        drain();

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

>>> uniform_grid_neighbour_query_top.f
src/ugnq_pkg.sv
src/ugnq_if.sv
src/ugnq_ram.sv
src/uniform_grid_neighbour_query_top.sv
tb/uniform_grid_neighbour_query_top_tb.sv
